FILE: design/lmpr_pkg.sv
// ----------------------------------------------------------------------------
// lmpr_pkg
// Turn and line codes, operation codes and turn selection helpers for the
// line maze path recorder.
// ----------------------------------------------------------------------------
package lmpr_pkg;

    localparam int TURN_W = 4;
    localparam int LINE_W = 3;
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;
    localparam int IDX_W  = 6;
    localparam int LEN_W  = 7;

    typedef logic [TURN_W-1:0] turn_t;
    typedef logic [LINE_W-1:0] line_t;
    typedef logic [OP_W-1:0]   op_t;
    typedef logic [STAT_W-1:0] stat_t;
    typedef logic [1:0]        quarter_t;

    // operation codes
    localparam op_t OP_CLEAR  = 3'd0;
    localparam op_t OP_RECORD = 3'd1;
    localparam op_t OP_FWD    = 3'd2;
    localparam op_t OP_BWD    = 3'd3;
    localparam op_t OP_SOLVE  = 3'd4;
    localparam op_t OP_FETCH  = 3'd5;

    // turn codes
    localparam turn_t T_STRAIGHT = 4'd0;
    localparam turn_t T_LEFT90   = 4'd1;
    localparam turn_t T_RIGHT90  = 4'd2;
    localparam turn_t T_LEFT180  = 4'd3;
    localparam turn_t T_RIGHT180 = 4'd4;
    localparam turn_t T_STOP     = 4'd5;
    localparam turn_t T_FINISHED = 4'd6;
    localparam turn_t T_STEP_FW  = 4'd7;
    localparam turn_t T_STEP_BW  = 4'd8;
    localparam turn_t T_POST_FW  = 4'd9;
    localparam turn_t T_POST_BW  = 4'd10;
    localparam turn_t T_LPOST_FW = 4'd11;
    localparam turn_t T_LPOST_BW = 4'd12;
    localparam turn_t T_MAX_CODE = 4'd12;

    // line kinds
    localparam line_t L_NONE     = 3'd0;
    localparam line_t L_STRAIGHT = 3'd1;
    localparam line_t L_LEFT     = 3'd2;
    localparam line_t L_RIGHT    = 3'd3;
    localparam line_t L_FULL     = 3'd4;

    // status codes
    localparam stat_t ST_OK   = 2'd0;
    localparam stat_t ST_FIN  = 2'd1;
    localparam stat_t ST_ERR  = 2'd2;

    // turn chosen on the way into the maze
    function automatic turn_t pick_forward(input line_t p, input line_t c, input logic lh);
        turn_t t;
        t = T_STOP;
        if (p == L_NONE && c == L_NONE)
            t = lh ? T_RIGHT180 : T_LEFT180;
        else if (p == L_FULL && c == L_NONE)
            t = lh ? T_LEFT90 : T_RIGHT90;
        else if (p == L_RIGHT && c == L_NONE)
            t = T_RIGHT90;
        else if (p == L_LEFT && c == L_NONE)
            t = T_LEFT90;
        else if (p == L_FULL && c == L_STRAIGHT)
            t = lh ? T_LEFT90 : T_RIGHT90;
        else if (p == L_FULL && c == L_FULL)
            t = T_FINISHED;
        else if (p == L_RIGHT && c == L_STRAIGHT)
            t = lh ? T_STRAIGHT : T_RIGHT90;
        else if (p == L_LEFT && c == L_STRAIGHT)
            t = lh ? T_LEFT90 : T_STRAIGHT;
        return t;
    endfunction

    // turn chosen on the way back
    function automatic turn_t pick_backward(input line_t p, input line_t c, input logic lh);
        turn_t t;
        t = T_STOP;
        if (p == L_LEFT && c == L_NONE)
            t = T_LEFT90;
        else if (p == L_RIGHT && c == L_NONE)
            t = T_RIGHT90;
        else if (p == L_RIGHT && c == L_STRAIGHT)
            t = lh ? T_RIGHT90 : T_LEFT180;
        else if (p == L_LEFT && c == L_STRAIGHT)
            t = lh ? T_RIGHT180 : T_LEFT90;
        else if (p == L_FULL && c == L_NONE)
            t = lh ? T_RIGHT90 : T_LEFT90;
        else if (p == L_FULL && c == L_STRAIGHT)
            t = lh ? T_RIGHT90 : T_LEFT90;
        return t;
    endfunction

    // mirrored turn for the backward path
    function automatic turn_t mirror(input turn_t t);
        turn_t m;
        case (t)
            T_LEFT90:   m = T_RIGHT90;
            T_RIGHT90:  m = T_LEFT90;
            T_LEFT180,
            T_RIGHT180,
            T_STRAIGHT: m = T_STRAIGHT;
            T_STEP_FW:  m = T_STEP_BW;
            T_STEP_BW:  m = T_STEP_FW;
            T_POST_FW:  m = T_POST_BW;
            T_POST_BW:  m = T_POST_FW;
            T_LPOST_FW: m = T_LPOST_BW;
            T_LPOST_BW: m = T_LPOST_FW;
            default:    m = T_STOP;
        endcase
        return m;
    endfunction

    // left and right quarter turns exchange
    function automatic turn_t swap_side(input turn_t t);
        turn_t s;
        s = t;
        if (t == T_LEFT90)
            s = T_RIGHT90;
        else if (t == T_RIGHT90)
            s = T_LEFT90;
        return s;
    endfunction

    // angle in quarter turns clockwise, so a sum wraps modulo 360 degrees
    function automatic quarter_t quarter_of(input turn_t t);
        quarter_t q;
        case (t)
            T_LEFT90:   q = 2'd3;
            T_RIGHT90:  q = 2'd1;
            T_LEFT180,
            T_RIGHT180: q = 2'd2;
            default:    q = 2'd0;
        endcase
        return q;
    endfunction

    // turn that stands for a summed angle
    function automatic turn_t turn_of(input quarter_t q);
        turn_t t;
        case (q)
            2'd1:    t = T_RIGHT90;
            2'd2:    t = T_LEFT180;
            2'd3:    t = T_LEFT90;
            default: t = T_STRAIGHT;
        endcase
        return t;
    endfunction

endpackage

FILE: design/lmpr_ram.sv
// ----------------------------------------------------------------------------
// lmpr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lmpr_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/line_maze_path_recorder.sv
// ----------------------------------------------------------------------------
// line_maze_path_recorder
// Stack of turn codes for a line maze robot, with junction rules, path
// simplification, path reversal and indexed read-back.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   content
//  s_axis    in         tvalid/tready               one operation item
//  m_axis    out        tvalid/tready               one result item per op
//  apb       in         psel/penable/pwrite/pready  left_hand_rule at 0x0
//
//  Items are taken one at a time: s_axis_tready is high only in the idle
//  state, so a new item waits until the result of the last one is handed
//  to the output register. Push, collapse and set solved step through the
//  turn store with one RAM port each for read and write.
//  Reset: control state clears at once; the turn store is not cleared, no
//  entry at or above the count is ever read.
//  A new item is taken while a result waits on m_axis; a finished result
//  that finds the output register full holds until m_tready frees it.
// ----------------------------------------------------------------------------
module line_maze_path_recorder #(
    parameter int PATH_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // operation[2:0], turn_in[6:3], prev_line[9:7], curr_line[12:10],
    // read_index[18:13], zero fill
    input  logic [23:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // turn_out[3:0], status[5:4], path_length[12:6], solved[13],
    // overflow[14], zero fill
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(PATH_DEPTH);
    localparam int CW = $clog2(PATH_DEPTH + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PUSH   = 4'd1;
    localparam logic [3:0] S_MID    = 4'd2;
    localparam logic [3:0] S_LOW    = 4'd3;
    localparam logic [3:0] S_RV_A   = 4'd4;
    localparam logic [3:0] S_RV_B   = 4'd5;
    localparam logic [3:0] S_RV_C   = 4'd6;
    localparam logic [3:0] S_RV_D   = 4'd7;
    localparam logic [3:0] S_RV_MID = 4'd8;
    localparam logic [3:0] S_FETCH  = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    // input fields
    lmpr_pkg::op_t     in_op;
    lmpr_pkg::turn_t   in_turn;
    lmpr_pkg::line_t   in_prev;
    lmpr_pkg::line_t   in_curr;
    logic [lmpr_pkg::IDX_W-1:0] in_idx;

    assign in_op   = s_axis_tdata[2:0];
    assign in_turn = s_axis_tdata[6:3];
    assign in_prev = s_axis_tdata[9:7];
    assign in_curr = s_axis_tdata[12:10];
    assign in_idx  = s_axis_tdata[18:13];

    // control state
    logic [3:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              solved_reg, solved_next;
    logic              lhr_reg, lhr_next;
    logic              out_valid_reg, out_valid_next;

    // payload state
    logic [15:0]       out_data_reg, out_data_next;
    lmpr_pkg::turn_t   turn_reg, turn_next;
    lmpr_pkg::stat_t   status_reg, status_next;
    logic              ovf_reg, ovf_next;
    lmpr_pkg::turn_t   push_reg, push_next;
    logic              simp_reg, simp_next;
    lmpr_pkg::turn_t   mid_reg, mid_next;
    lmpr_pkg::turn_t   hold_reg, hold_next;
    logic [AW-1:0]     i_reg, i_next;
    logic [AW-1:0]     j_reg, j_next;

    // ram ports
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    lmpr_pkg::turn_t   wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    lmpr_pkg::turn_t   rd_data;

    logic              in_fire;
    logic              cfg_wr;
    lmpr_pkg::turn_t   pick;
    lmpr_pkg::quarter_t qsum;

    lmpr_ram #(
        .WIDTH (lmpr_pkg::TURN_W),
        .DEPTH (PATH_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // handshakes
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];

    always_comb
    begin
        prdata = 32'd0;
        if (!paddr[2])
        begin
            prdata = {31'd0, lhr_reg};
        end
    end

    // angle sum of the collapsing triple
    assign qsum = lmpr_pkg::quarter_of(rd_data) + lmpr_pkg::quarter_of(mid_reg)
                + lmpr_pkg::quarter_of(push_reg);

    // main sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        solved_next    = solved_reg;
        lhr_next       = cfg_wr ? pwdata[0] : lhr_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        turn_next      = turn_reg;
        status_next    = status_reg;
        ovf_next       = ovf_reg;
        push_next      = push_reg;
        simp_next      = simp_reg;
        mid_next       = mid_reg;
        hold_next      = hold_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        wr_en          = 1'b0;
        wr_addr        = AW'(count_reg);
        wr_data        = push_reg;
        rd_en          = 1'b0;
        rd_addr        = i_reg;
        pick           = lmpr_pkg::T_STOP;

        // output register drains independently
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            // decode a new item
            S_IDLE:
            begin
                if (in_fire)
                begin
                    status_next = lmpr_pkg::ST_OK;
                    ovf_next    = 1'b0;
                    simp_next   = 1'b1;
                    turn_next   = lmpr_pkg::T_STOP;
                    state_next  = S_DONE;
                    case (in_op)
                        lmpr_pkg::OP_CLEAR:
                        begin
                            count_next  = '0;
                            solved_next = 1'b0;
                            turn_next   = lmpr_pkg::T_STRAIGHT;
                        end
                        lmpr_pkg::OP_RECORD:
                        begin
                            pick       = (in_turn > lmpr_pkg::T_MAX_CODE) ?
                                         lmpr_pkg::T_STOP : in_turn;
                            turn_next  = pick;
                            push_next  = pick;
                            state_next = S_PUSH;
                        end
                        lmpr_pkg::OP_FWD:
                        begin
                            pick      = lmpr_pkg::pick_forward(in_prev, in_curr, lhr_reg);
                            turn_next = pick;
                            push_next = pick;
                            if (pick == lmpr_pkg::T_FINISHED)
                                status_next = lmpr_pkg::ST_FIN;
                            else if (pick == lmpr_pkg::T_STOP)
                                status_next = lmpr_pkg::ST_ERR;
                            else
                                state_next = S_PUSH;
                        end
                        lmpr_pkg::OP_BWD:
                        begin
                            pick      = lmpr_pkg::pick_backward(in_prev, in_curr, lhr_reg);
                            turn_next = pick;
                            push_next = lmpr_pkg::mirror(pick);
                            if (pick == lmpr_pkg::T_STOP)
                                status_next = lmpr_pkg::ST_ERR;
                            else
                                state_next = S_PUSH;
                        end
                        lmpr_pkg::OP_SOLVE:
                        begin
                            solved_next = 1'b1;
                            push_next   = lmpr_pkg::T_STOP;
                            simp_next   = 1'b0;
                            i_next      = '0;
                            j_next      = AW'(count_reg - CW'(1));
                            state_next  = (count_reg == '0) ? S_PUSH : S_RV_A;
                        end
                        lmpr_pkg::OP_FETCH:
                        begin
                            if (32'(in_idx) < 32'(count_reg) && 32'(in_idx) < PATH_DEPTH)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(in_idx);
                                state_next = S_FETCH;
                            end
                            else
                            begin
                                status_next = lmpr_pkg::ST_ERR;
                            end
                        end
                        default:
                        begin
                            status_next = lmpr_pkg::ST_ERR;
                        end
                    endcase
                end
            end

            // write the pushed turn, fetch the entry below it
            S_PUSH:
            begin
                state_next = S_DONE;
                if (count_reg >= CW'(PATH_DEPTH))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    if (simp_reg && count_reg >= CW'(2))
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(count_reg - CW'(1));
                        state_next = S_MID;
                    end
                end
            end

            // middle entry of the triple: only a U-turn collapses
            S_MID:
            begin
                mid_next   = rd_data;
                state_next = S_DONE;
                if (rd_data == lmpr_pkg::T_LEFT180 || rd_data == lmpr_pkg::T_RIGHT180)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(count_reg - CW'(3));
                    state_next = S_LOW;
                end
            end

            // collapse the triple into its lowest entry
            S_LOW:
            begin
                wr_en      = 1'b1;
                wr_addr    = AW'(count_reg - CW'(3));
                wr_data    = lmpr_pkg::turn_of(qsum);
                count_next = count_reg - CW'(2);
                state_next = S_DONE;
            end

            // reversal: read the low entry of the pair
            S_RV_A:
            begin
                if (i_reg < j_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = i_reg;
                    state_next = S_RV_B;
                end
                else if (i_reg == j_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = i_reg;
                    state_next = S_RV_MID;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end

            // hold the low entry, read the high one
            S_RV_B:
            begin
                hold_next  = rd_data;
                rd_en      = 1'b1;
                rd_addr    = j_reg;
                state_next = S_RV_C;
            end

            // high entry goes low
            S_RV_C:
            begin
                wr_en      = 1'b1;
                wr_addr    = i_reg;
                wr_data    = lmpr_pkg::swap_side(rd_data);
                state_next = S_RV_D;
            end

            // low entry goes high, step inwards
            S_RV_D:
            begin
                wr_en      = 1'b1;
                wr_addr    = j_reg;
                wr_data    = lmpr_pkg::swap_side(hold_reg);
                i_next     = i_reg + AW'(1);
                j_next     = j_reg - AW'(1);
                state_next = S_RV_A;
            end

            // centre entry of an odd path swaps in place
            S_RV_MID:
            begin
                wr_en      = 1'b1;
                wr_addr    = i_reg;
                wr_data    = lmpr_pkg::swap_side(rd_data);
                state_next = S_PUSH;
            end

            // fetched entry
            S_FETCH:
            begin
                turn_next  = rd_data;
                state_next = S_DONE;
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, ovf_reg, solved_reg,
                                      lmpr_pkg::LEN_W'(count_reg), status_reg, turn_reg};
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            solved_reg    <= 1'b0;
            lhr_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            solved_reg    <= solved_next;
            lhr_reg       <= lhr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        turn_reg     <= turn_next;
        status_reg   <= status_next;
        ovf_reg      <= ovf_next;
        push_reg     <= push_next;
        simp_reg     <= simp_next;
        mid_reg      <= mid_next;
        hold_reg     <= hold_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
    end

endmodule
